### src/prbd_pkg.sv
// Shared types and constants for the binary PLC response deframer.
package prbd_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 9;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned LENGTH_W = 16;

  // Length values below this end the frame right after the header.
  localparam logic [LENGTH_W-1:0] END_CODE_BYTES = 16'd2;

  // Bit positions tested in a packed-bit data byte.
  localparam int unsigned EVEN_BIT_POS = 4;
  localparam int unsigned ODD_BIT_POS  = 0;

  // Packed port layouts.
  localparam int unsigned IN_TDATA_W  = 24;  // rx_byte, base_index
  localparam int unsigned IN_TUSER_W  = 2;   // word_mode, store_reply
  localparam int unsigned OUT_TDATA_W = 32;  // write_index, write_value
  localparam int unsigned OUT_TUSER_W = 2;   // write_valid, frame_done

  typedef struct packed {
    logic                       write_valid;
    logic [INDEX_W-1:0]         write_index;
    logic signed [VALUE_W-1:0]  write_value;
    logic                       frame_done;
    logic                       last_of_run;
  } result_t;

  // Up to two results caused by one byte, with their count.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

endpackage

### src/prbd_parser.sv
// Frame parser: per-byte header/body tracking and result generation.
module prbd_parser #(
  parameter int unsigned HEADER_BYTES = prbd_pkg::HEADER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic [prbd_pkg::BYTE_W-1:0]         rx_byte,
  input  logic                                word_mode,
  input  logic                                store_reply,
  input  logic [prbd_pkg::INDEX_W-1:0]        base_index,
  output prbd_pkg::res_pair_t                 pair
);
  import prbd_pkg::*;

  localparam int unsigned HC_W = $clog2(HEADER_BYTES + 1);
  localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES);
  localparam logic [HC_W-1:0] HC_LEN_LO = HC_W'(HEADER_BYTES - 2);
  localparam logic [HC_W-1:0] HC_LEN_HI = HC_W'(HEADER_BYTES - 1);

  logic [HC_W-1:0]      hc_r, hc_nxt;
  logic [LENGTH_W-1:0]  fl_r, fl_nxt;
  logic [LENGTH_W-1:0]  bc_r, bc_nxt;
  logic [BYTE_W-1:0]    lo_r, lo_nxt;
  logic                 wm_r, wm_nxt;
  logic                 st_r, st_nxt;
  logic [INDEX_W-1:0]   wp_r, wp_nxt;

  always_comb begin
    logic done;
    logic [1:0] n;
    result_t r0, r1;
    hc_nxt = hc_r;
    fl_nxt = fl_r;
    bc_nxt = bc_r;
    lo_nxt = lo_r;
    wm_nxt = wm_r;
    st_nxt = st_r;
    wp_nxt = wp_r;
    done   = 1'b0;
    n      = 2'd0;
    r0     = '0;
    r1     = '0;
    if (hc_r < HC_LAST) begin
      if (hc_r == '0) begin
        wm_nxt = word_mode;
        st_nxt = store_reply;
        wp_nxt = base_index;
        fl_nxt = '0;
      end
      if (hc_r == HC_LEN_LO) fl_nxt = {fl_nxt[LENGTH_W-1:BYTE_W], rx_byte};
      if (hc_r == HC_LEN_HI) fl_nxt = {rx_byte, fl_nxt[BYTE_W-1:0]};
      hc_nxt = hc_r + 1'b1;
      if (hc_nxt == HC_LAST) begin
        bc_nxt = '0;
        if (fl_nxt < END_CODE_BYTES) begin
          done   = 1'b1;
          hc_nxt = '0;
        end
      end
    end else begin
      // Data bytes follow the end code; parity of the data offset equals bc parity.
      if (bc_r >= END_CODE_BYTES && st_r) begin
        if (wm_r) begin
          if (!bc_r[0]) begin
            lo_nxt = rx_byte;
          end else begin
            r0.write_valid = 1'b1;
            r0.write_index = wp_r;
            r0.write_value = {rx_byte, lo_r};
            n      = 2'd1;
            wp_nxt = wp_r + 1'b1;
          end
        end else begin
          r0.write_valid = 1'b1;
          r0.write_index = wp_r;
          r0.write_value = {VALUE_W{rx_byte[EVEN_BIT_POS]}};
          r1.write_valid = 1'b1;
          r1.write_index = wp_r + 1'b1;
          r1.write_value = {VALUE_W{rx_byte[ODD_BIT_POS]}};
          n      = 2'd2;
          wp_nxt = wp_r + 2'd2;
        end
      end
      bc_nxt = bc_r + 1'b1;
      if (bc_nxt >= fl_r) begin
        done   = 1'b1;
        hc_nxt = '0;
      end
    end
    // A completing byte without a write still reports the frame end.
    if (done && n == 2'd0) n = 2'd1;
    r0.frame_done  = done;
    r1.frame_done  = done;
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
    pair.cnt = n;
    pair.r0  = r0;
    pair.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
      fl_r <= '0;
      bc_r <= '0;
      lo_r <= '0;
      wm_r <= 1'b0;
      st_r <= 1'b0;
      wp_r <= '0;
    end else if (fire) begin
      hc_r <= hc_nxt;
      fl_r <= fl_nxt;
      bc_r <= bc_nxt;
      lo_r <= lo_nxt;
      wm_r <= wm_nxt;
      st_r <= st_nxt;
      wp_r <= wp_nxt;
    end
  end

endmodule

### src/prbd_emitter.sv
// Result register: holds up to two results of one byte and sends them in order.
module prbd_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prbd_pkg::res_pair_t  pair,
  input  logic                 pair_valid,
  output logic                 pair_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  output prbd_pkg::result_t    res
);
  import prbd_pkg::*;

  logic      busy_r, busy_nxt;
  logic      sel_r, sel_nxt;
  logic      two_r, two_nxt;
  result_t   r0_r, r1_r;
  logic      xfer, final_xfer, load;

  assign xfer       = busy_r && res_ready;
  assign final_xfer = xfer && (sel_r || !two_r);
  assign pair_ready = !busy_r || final_xfer;
  // Byte consumed; load only when it produced results.
  assign load       = pair_valid && pair_ready && (pair.cnt != 2'd0);

  assign res_valid = busy_r;
  assign res       = sel_r ? r1_r : r0_r;

  always_comb begin
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    two_nxt  = two_r;
    if (final_xfer) begin
      busy_nxt = 1'b0;
    end else if (xfer) begin
      sel_nxt = 1'b1;
    end
    if (load) begin
      busy_nxt = 1'b1;
      sel_nxt  = 1'b0;
      two_nxt  = (pair.cnt == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 1'b0;
      two_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
      two_r  <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0_r <= pair.r0;
      r1_r <= pair.r1;
    end
  end

endmodule

### src/plc_binary_response_deframer_core.sv
// Top level of the binary PLC read-response deframer.
//
//  Channel  Dir  Ports                      Payload (lowest bits first)
//  in_      in   tvalid/tready/tdata/tuser  tdata: rx_byte, base_index; tuser: word_mode, store_reply
//  out_     out  tvalid/tready/tdata/tuser  tdata: write_index, write_value;
//                /tlast                     tuser: write_valid, frame_done; tlast: last_of_run
//
// Each accepted byte lands in an input register; the parser turns it into zero, one or
// two results and hands them to the result register. Header bytes, end code and word
// low bytes yield no write; a packed-bit data byte yields two results, sent in order
// through the single result port (one result per cycle while out_ is ready).
// Reset (rst_n low, synchronous) empties both registers and returns to frame start.
// Back-pressure on out_ stalls the result register, then the input register, then in_.
module plc_binary_response_deframer_core #(
  parameter int unsigned HEADER_BYTES = prbd_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [prbd_pkg::IN_TDATA_W-1:0]    in_tdata,   // rx_byte[7:0], base_index[23:8]
  input  logic [prbd_pkg::IN_TUSER_W-1:0]    in_tuser,   // word_mode[0], store_reply[1]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [prbd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // write_index[15:0], write_value[31:16]
  output logic [prbd_pkg::OUT_TUSER_W-1:0]   out_tuser,  // write_valid[0], frame_done[1]
  output logic                               out_tlast   // last_of_run
);
  import prbd_pkg::*;

  // Input register.
  logic                    iv_r;
  logic [BYTE_W-1:0]       byte_r;
  logic                    wm_r;
  logic                    st_r;
  logic [INDEX_W-1:0]      base_r;

  res_pair_t pair;
  logic      pair_ready;
  logic      fire;
  result_t   res;

  // Parser advances when the result register accepts the held byte.
  assign fire      = iv_r && pair_ready;
  assign in_tready = !iv_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tready) begin
      iv_r <= in_tvalid;
    end
  end

  // Hold payload until the parser consumes it.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata[BYTE_W-1:0];
      base_r <= in_tdata[BYTE_W+INDEX_W-1:BYTE_W];
      wm_r   <= in_tuser[0];
      st_r   <= in_tuser[1];
    end
  end

  prbd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (byte_r),
    .word_mode   (wm_r),
    .store_reply (st_r),
    .base_index  (base_r),
    .pair        (pair)
  );

  prbd_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair       (pair),
    .pair_valid (iv_r),
    .pair_ready (pair_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // Pack the result fields onto the output bus.
  assign out_tdata = {res.write_value, res.write_index};
  assign out_tuser = {res.frame_done, res.write_valid};
  assign out_tlast = res.last_of_run;

endmodule

### tb/tb_plc_binary_response_deframer_core.sv
// Self-checking testbench for the binary PLC response deframer: framed byte stimulus, result check.
module tb_plc_binary_response_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import prbd_pkg::*;

  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int unsigned HOLD_CYCLES   = 200;
  // Bound on the wait for outstanding results at the end of the run.
  localparam int unsigned DRAIN_LIMIT   = 20000;
  // Quiet cycles after the last result, to catch stray transfers.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_BYTES  = 560;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  // Receiver ready patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_pattern_e;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // rx_byte[7:0], base_index[23:8]
  logic [IN_TUSER_W-1:0]  in_tuser;   // word_mode[0], store_reply[1]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // write_index[15:0], write_value[31:16]
  logic [OUT_TUSER_W-1:0] out_tuser;  // write_valid[0], frame_done[1]
  logic                   out_tlast;  // last_of_run

  plc_binary_response_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow of the deframer state, advanced once per accepted byte.
  int unsigned        hdr_seen;
  logic [15:0]        frm_len;
  logic [15:0]        body_seen;
  logic [7:0]         low_hold;
  logic               lat_word;
  logic               lat_store;
  logic [15:0]        wr_ptr;

  // Store writes and frame completions still owed by the block, oldest first.
  result_t            pending_writes[$];
  // Body bytes a directed frame should carry; anything beyond is random.
  logic [7:0]         frame_body[$];

  int unsigned        mismatches;
  int unsigned        bytes_sent;
  int unsigned        frames_sent;
  int unsigned        results_checked;
  int unsigned        writes_checked;
  int unsigned        frames_closed;
  int unsigned        burst_left;
  bit                 hold_req;
  int unsigned        stalls_seen;

  // 8 ns clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d results still owed after %0d bytes", pending_writes.size(),
             bytes_sent);
    $display("Mismatches found");
    $finish;
  end

  function automatic string fmt_result(result_t r);
    return $sformatf("valid=%0d idx=%04h val=%04h done=%0d last=%0d", r.write_valid,
                     r.write_index, r.write_value, r.frame_done, r.last_of_run);
  endfunction

  // Count every mismatch, print only the first few.
  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic result_t store_write(logic [15:0] idx, logic [15:0] val);
    result_t r;
    r             = '0;
    r.write_valid = 1'b1;
    r.write_index = idx;
    r.write_value = val;
    return r;
  endfunction

  // Advance the shadow state by one accepted byte and queue the results it owes.
  task automatic predict_byte(input logic [7:0] rx, input logic wm, input logic st,
                              input logic [15:0] base);
    result_t     batch[$];
    result_t     r;
    logic [15:0] data_off;
    bit          fin;
    fin = 1'b0;
    if (hdr_seen < HEADER_BYTES_DEF) begin
      // Latch the frame controls on the first header byte only.
      if (hdr_seen == 0) begin
        lat_word  = wm;
        lat_store = st;
        wr_ptr    = base;
        frm_len   = '0;
      end
      // Length travels little-endian in the last two header bytes.
      if (hdr_seen == HEADER_BYTES_DEF - 2) frm_len[7:0] = rx;
      if (hdr_seen == HEADER_BYTES_DEF - 1) frm_len[15:8] = rx;
      hdr_seen++;
      if (hdr_seen == HEADER_BYTES_DEF) begin
        body_seen = '0;
        // Short length: the frame closes on the last header byte.
        if (frm_len < END_CODE_BYTES) begin
          fin      = 1'b1;
          hdr_seen = 0;
        end
      end
    end else begin
      // Skip the end code; only stored replies write.
      if (body_seen >= END_CODE_BYTES && lat_store) begin
        data_off = body_seen - END_CODE_BYTES;
        if (lat_word) begin
          if (!data_off[0]) begin
            low_hold = rx;
          end else begin
            batch.push_back(store_write(wr_ptr, {rx, low_hold}));
            wr_ptr = wr_ptr + 16'd1;
          end
        end else begin
          batch.push_back(store_write(wr_ptr, rx[EVEN_BIT_POS] ? 16'hFFFF : 16'h0000));
          batch.push_back(store_write(wr_ptr + 16'd1,
                                      rx[ODD_BIT_POS] ? 16'hFFFF : 16'h0000));
          wr_ptr = wr_ptr + 16'd2;
        end
      end
      body_seen = body_seen + 16'd1;
      if (body_seen >= frm_len) begin
        fin      = 1'b1;
        hdr_seen = 0;
      end
    end
    // A completing byte with no write still owes one empty marker result.
    if (batch.size() == 0 && fin) begin
      batch.push_back('0);
    end
    foreach (batch[k]) begin
      r             = batch[k];
      r.frame_done  = fin;
      r.last_of_run = (k == batch.size() - 1);
      pending_writes.push_back(r);
    end
  endtask

  // Offer one byte and hold it until the transfer; leaves in_tvalid high.
  // Bursts of random length separated by random gaps; a zero gap keeps streaming.
  task automatic send_byte(input logic [7:0] rx, input logic wm, input logic st,
                           input logic [15:0] base);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {base, rx};
    in_tuser  <= {st, wm};
    do @(posedge clk); while (!in_tready);
    predict_byte(rx, wm, st, base);
    bytes_sent++;
  endtask

  // Send one frame: header with the given length, then the body. Controls on
  // bytes other than the first are randomized since the block must ignore them.
  task automatic send_frame(input logic wm, input logic st, input logic [15:0] base,
                            input logic [15:0] len);
    logic [7:0]  b;
    int unsigned i;
    for (i = 0; i < HEADER_BYTES_DEF; i++) begin
      if (i == HEADER_BYTES_DEF - 2)      b = len[7:0];
      else if (i == HEADER_BYTES_DEF - 1) b = len[15:8];
      else                                b = 8'($urandom_range(0, 255));
      if (i == 0) send_byte(b, wm, st, base);
      else send_byte(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
    end
    // Short lengths end at the header, so no body follows.
    if (len >= END_CODE_BYTES) begin
      for (i = 0; i < len; i++) begin
        b = (i < frame_body.size()) ? frame_body[i] : 8'($urandom_range(0, 255));
        send_byte(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
      end
    end
    frame_body.delete();
    frames_sent++;
  endtask

  // Drop valid and pause the sender until every owed result has come back.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // Hand-picked frames: extremes, both modes, discard, short lengths, odd leftover, wrap.
  task automatic test_directed();
    // Word mode, three words including all-zero and all-one.
    frame_body = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h34, 8'h12};
    send_frame(1'b1, 1'b1, 16'h0000, 16'd8);
    // Bit mode, every combination of bit 4 and bit 0.
    frame_body = {8'hFF, 8'hFF, 8'h11, 8'h10, 8'h01, 8'h00, 8'hEE};
    send_frame(1'b0, 1'b1, 16'h0010, 16'd7);
    // Word mode with an unpaired last data byte.
    frame_body = {8'h00, 8'h00, 8'hCD, 8'hAB, 8'h7F};
    send_frame(1'b1, 1'b1, 16'h0100, 16'd5);
    // Discarded reply, consumed up to its length.
    send_frame(1'b0, 1'b0, 16'h1234, 16'd4);
    send_frame(1'b1, 1'b0, 16'h4321, 16'd3);
    // Short lengths and the end-code-only frame.
    send_frame(1'b1, 1'b1, 16'h0001, 16'd0);
    send_frame(1'b0, 1'b1, 16'h0002, 16'd1);
    send_frame(1'b1, 1'b1, 16'h0003, 16'd2);
    // Index wrap in both modes.
    frame_body = {8'h00, 8'h00, 8'hFF, 8'hEE};
    send_frame(1'b0, 1'b1, 16'hFFFF, 16'd4);
    frame_body = {8'h00, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h7F};
    send_frame(1'b1, 1'b1, 16'hFFFF, 16'd6);
    wait_results_drained();
  endtask

  // Mostly well-formed frames with random content, some stray bytes between them.
  task automatic test_random_frames(input int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    logic        wm;
    logic        st;
    logic [15:0] base;
    logic [15:0] len;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      wm   = 1'($urandom_range(0, 1));
      st   = ($urandom_range(0, 3) != 0);
      base = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                         : 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) begin
        // Stray bytes knock the stream out of frame alignment.
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 39) == 0)     len = 16'($urandom_range(256, 264));
        else if ($urandom_range(0, 3) == 0) len = 16'($urandom_range(0, 3));
        else                                len = 16'($urandom_range(4, 24));
        send_frame(wm, st, base, len);
      end
    end
    wait_results_drained();
  endtask

  // Hold the receiver off while a long bit-mode frame streams in, so the block backs up.
  task automatic test_backpressure();
    int unsigned stalls_prior;
    stalls_prior = stalls_seen;
    hold_req     = 1'b1;
    send_frame(1'b0, 1'b1, 16'h8000, 16'd40);
    wait_results_drained();
    if (stalls_seen == stalls_prior) begin
      $display("Note: input never stalled during the receiver hold-off");
    end
  endtask

  // Short frames, with the sender paused for a full drain after each.
  task automatic test_drain_pauses();
    int unsigned i;
    for (i = 0; i < 4; i++) begin
      send_frame(1'($urandom_range(0, 1)), 1'b1, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(2, 10)));
      wait_results_drained();
    end
  endtask

  // Receiver: a long hold-off on request, otherwise a ready pattern that changes now and then.
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned pattern_left;
    int unsigned hold_left;
    out_tready   <= 1'b0;
    pattern      = RX_ALWAYS;
    pattern_left = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = rx_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          RX_ALWAYS:    out_tready <= 1'b1;
          RX_COIN:      out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:    out_tready <= ($urandom_range(0, 3) == 0);
          RX_ALTERNATE: out_tready <= ~out_tready;
          default:      out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Count cycles where the block refuses an offered byte.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) begin
      stalls_seen++;
    end
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.write_valid = out_tuser[0];
      got.frame_done  = out_tuser[1];
      got.write_index = out_tdata[15:0];
      got.write_value = out_tdata[31:16];
      got.last_of_run = out_tlast;
      results_checked++;
      if (got.write_valid === 1'b1) writes_checked++;
      if (got.frame_done === 1'b1 && got.last_of_run === 1'b1) frames_closed++;
      if (pending_writes.size() == 0) begin
        log_mismatch($sformatf("unexpected result: %s", fmt_result(got)));
      end else begin
        want = pending_writes.pop_front();
        if (got.write_valid !== want.write_valid || got.write_index !== want.write_index ||
            got.write_value !== want.write_value || got.frame_done !== want.frame_done ||
            got.last_of_run !== want.last_of_run) begin
          log_mismatch($sformatf("result %0d: expected %s, got %s", results_checked,
                                 fmt_result(want), fmt_result(got)));
        end
      end
    end
  end

  initial begin : main
    int unsigned waited;
    mismatches      = 0;
    bytes_sent      = 0;
    frames_sent     = 0;
    results_checked = 0;
    writes_checked  = 0;
    frames_closed   = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    stalls_seen     = 0;
    hdr_seen        = 0;
    frm_len         = '0;
    body_seen       = '0;
    low_hold        = '0;
    lat_word        = 1'b0;
    lat_store       = 1'b0;
    wr_ptr          = '0;
    rst_n           <= 1'b0;
    in_tvalid       <= 1'b0;
    in_tdata        <= '0;
    in_tuser        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_drain_pauses();
    test_random_frames(RANDOM_BYTES);

    // Drain whatever is still owed, bounded, then let the outputs settle.
    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_writes.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived, oldest %s", pending_writes.size(),
                             fmt_result(pending_writes[0])));
    end

    $display("Covered %0d bytes in %0d frames, both modes, discards, short lengths, wrap.",
             bytes_sent, frames_sent);
    $display("Checked %0d results (%0d writes, %0d frame ends), %0d input stall cycles.",
             results_checked, writes_checked, frames_closed, stalls_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
